// ===== rtl/odc_pkg.sv =====
// ----------------------------------------------------------------------------
// odc_pkg
// shared types, register indexes, reset values and mode codes of the
// obstacle avoiding drive controller
// ----------------------------------------------------------------------------
package odc_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_THR  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WALL_NEAR_THR = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOO_CLOSE_THR = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CRUISE_SPEED  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_SPEED    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_SPEED    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKUP_TIME   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_TIME     = 4'd7;

  // field widths
  localparam int THR_W   = 13;
  localparam int SPEED_W = 7;
  localparam int TIME_W  = 16;
  localparam int DIST_W  = 16;
  localparam int NOW_W   = 32;
  localparam int STAT_W  = 8;
  localparam int WHEEL_W = 8;
  localparam int MODE_W  = 3;
  localparam int RING_N  = 4;
  localparam int PTR_W   = 2;

  // register reset values
  localparam logic [THR_W-1:0]   OBSTACLE_THR_RST  = 13'd200;
  localparam logic [THR_W-1:0]   WALL_NEAR_THR_RST = 13'd150;
  localparam logic [THR_W-1:0]   TOO_CLOSE_THR_RST = 13'd100;
  localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST  = 7'd60;
  localparam logic [SPEED_W-1:0] TURN_SPEED_RST    = 7'd40;
  localparam logic [SPEED_W-1:0] SLOW_SPEED_RST    = 7'd30;
  localparam logic [TIME_W-1:0]  BACKUP_TIME_RST   = 16'd500;
  localparam logic [TIME_W-1:0]  TURN_TIME_RST     = 16'd300;

  localparam logic [DIST_W-1:0]  INVALID_DISTANCE  = 16'd8190;
  localparam logic [SPEED_W-1:0] SPEED_MAX         = 7'd100;

  // drive modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CRUISE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AVOID  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WALL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BACKUP = 3'd6;

  typedef logic [RING_N-1:0][DIST_W-1:0] ring_t;

  typedef struct packed {
    logic [THR_W-1:0]   obstacle_thr;
    logic [THR_W-1:0]   wall_near_thr;
    logic [THR_W-1:0]   too_close_thr;
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] turn_speed;
    logic [SPEED_W-1:0] slow_speed;
    logic [TIME_W-1:0]  backup_time;
    logic [TIME_W-1:0]  turn_time;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    ring_t                     ring;
    logic [PTR_W-1:0]          ptr;
    logic [NOW_W-1:0]          turn_deadline;
    logic [NOW_W-1:0]          backup_deadline;
    logic                      turn_right_last;
    logic signed [WHEEL_W-1:0] held_left;
    logic signed [WHEEL_W-1:0] held_right;
    logic [DIST_W-1:0]         held_distance;
  } drive_state_t;

  typedef struct packed {
    logic                      command;
    logic [DIST_W-1:0]         raw_distance;
    logic [STAT_W-1:0]         sensor_status;
    logic [NOW_W-1:0]          now_ms;
  } item_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] left_speed;
    logic signed [WHEEL_W-1:0] right_speed;
    logic                      obstacle_flag;
    logic [DIST_W-1:0]         filtered_distance;
    logic [MODE_W-1:0]         mode;
  } result_t;

  // clamp a speed register to the percent range
  function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] v);
    return (v > SPEED_MAX) ? SPEED_MAX : v;
  endfunction

  function automatic logic signed [WHEEL_W-1:0] fwd(input logic [SPEED_W-1:0] v);
    return $signed({1'b0, sat_speed(v)});
  endfunction

  function automatic logic signed [WHEEL_W-1:0] rev(input logic [SPEED_W-1:0] v);
    logic signed [WHEEL_W-1:0] p;
    p = $signed({1'b0, sat_speed(v)});
    return -p;
  endfunction

endpackage

// ===== rtl/obstacle_avoid_drive_controller.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_controller
// median filtered range input and drive mode machine for a two wheel robot
// ----------------------------------------------------------------------------
// Each word is either a start command or one range sample with a millisecond
// time stamp, and every word gives exactly one result word. A word is held in
// the input register, the filter and mode logic work on it there, and the
// result lands in the output register; a new word is taken every cycle as
// long as the output side keeps up. Each word reads the drive state that the
// previous word left in the drive state registers. Configuration writes are
// taken every cycle and must only be made while no word is in flight.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_controller (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [odc_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [odc_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic [odc_pkg::DIST_W-1:0]             raw_distance_i,
  input  logic [odc_pkg::STAT_W-1:0]             sensor_status_i,
  input  logic [odc_pkg::NOW_W-1:0]              now_ms_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [odc_pkg::WHEEL_W-1:0]     left_speed_o,
  output logic signed [odc_pkg::WHEEL_W-1:0]     right_speed_o,
  output logic                                   obstacle_flag_o,
  output logic [odc_pkg::DIST_W-1:0]             filtered_distance_o,
  output logic [odc_pkg::MODE_W-1:0]             mode_o
);

  odc_pkg::cfg_t          cfg;
  odc_pkg::item_t         item_q;
  logic                   item_valid_q;
  logic                   item_adv;
  logic                   in_take;
  odc_pkg::drive_state_t  state_d, state_q;
  odc_pkg::result_t       result_d, result_q;
  logic                   out_valid_q;
  odc_pkg::ring_t         ring_new;
  logic [odc_pkg::PTR_W-1:0]  ptr_new;
  logic [odc_pkg::DIST_W-1:0] distance;

  odc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // the held word moves on when the output register is empty or being emptied
  assign item_adv   = item_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = item_valid_q & ~item_adv;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (item_adv) begin
      item_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command       <= command_i;
      item_q.raw_distance  <= raw_distance_i;
      item_q.sensor_status <= sensor_status_i;
      item_q.now_ms        <= now_ms_i;
    end
  end

  // ring write and median of four
  odc_filter u_filter (
    .ring_i          (state_q.ring),
    .ptr_i           (state_q.ptr),
    .raw_distance_i  (item_q.raw_distance),
    .sensor_status_i (item_q.sensor_status),
    .ring_o          (ring_new),
    .ptr_o           (ptr_new),
    .distance_o      (distance)
  );

  // mode rules and wheel speeds
  odc_mode_ctrl u_mode (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .item_i     (item_q),
    .ring_i     (ring_new),
    .ptr_i      (ptr_new),
    .distance_i (distance),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // drive state only changes when a word is actually processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode            <= odc_pkg::MODE_IDLE;
      state_q.ring            <= '0;
      state_q.ptr             <= '0;
      state_q.turn_deadline   <= '0;
      state_q.backup_deadline <= '0;
      state_q.turn_right_last <= 1'b1;
      state_q.held_left       <= '0;
      state_q.held_right      <= '0;
      state_q.held_distance   <= '0;
    end else if (item_adv) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_adv) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_adv) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign left_speed_o        = result_q.left_speed;
  assign right_speed_o       = result_q.right_speed;
  assign obstacle_flag_o     = result_q.obstacle_flag;
  assign filtered_distance_o = result_q.filtered_distance;
  assign mode_o              = result_q.mode;

  // checks

  // a stall on the input side only happens with a word held inside
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid_q)
    else $error("input stalled with empty input register");

  // a processed word always shows up at the output next cycle
  a_adv_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_adv |=> out_valid_o)
    else $error("processed word did not reach the output register");

  // a start command always lands in cruise
  a_start_cruise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_adv && item_q.command) |=> (state_q.mode == odc_pkg::MODE_CRUISE &&
                                      mode_o == odc_pkg::MODE_CRUISE))
    else $error("start command did not enter cruise");

  // wheels are stopped whenever the machine reports idle
  a_idle_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_o == odc_pkg::MODE_IDLE) |->
      (left_speed_o == '0 && right_speed_o == '0))
    else $error("nonzero wheel speed in idle");

endmodule

// ===== rtl/odc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// odc_cfg_regs
// configuration register file, one write per handshake, unknown index ignored
// ----------------------------------------------------------------------------
module odc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [odc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [odc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output odc_pkg::cfg_t                   cfg_o
);

  odc_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        odc_pkg::REG_OBSTACLE_THR:  cfg_d.obstacle_thr  = cfg_data_i[odc_pkg::THR_W-1:0];
        odc_pkg::REG_WALL_NEAR_THR: cfg_d.wall_near_thr = cfg_data_i[odc_pkg::THR_W-1:0];
        odc_pkg::REG_TOO_CLOSE_THR: cfg_d.too_close_thr = cfg_data_i[odc_pkg::THR_W-1:0];
        odc_pkg::REG_CRUISE_SPEED:  cfg_d.cruise_speed  = cfg_data_i[odc_pkg::SPEED_W-1:0];
        odc_pkg::REG_TURN_SPEED:    cfg_d.turn_speed    = cfg_data_i[odc_pkg::SPEED_W-1:0];
        odc_pkg::REG_SLOW_SPEED:    cfg_d.slow_speed    = cfg_data_i[odc_pkg::SPEED_W-1:0];
        odc_pkg::REG_BACKUP_TIME:   cfg_d.backup_time   = cfg_data_i[odc_pkg::TIME_W-1:0];
        odc_pkg::REG_TURN_TIME:     cfg_d.turn_time     = cfg_data_i[odc_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obstacle_thr  <= odc_pkg::OBSTACLE_THR_RST;
      cfg_q.wall_near_thr <= odc_pkg::WALL_NEAR_THR_RST;
      cfg_q.too_close_thr <= odc_pkg::TOO_CLOSE_THR_RST;
      cfg_q.cruise_speed  <= odc_pkg::CRUISE_SPEED_RST;
      cfg_q.turn_speed    <= odc_pkg::TURN_SPEED_RST;
      cfg_q.slow_speed    <= odc_pkg::SLOW_SPEED_RST;
      cfg_q.backup_time   <= odc_pkg::BACKUP_TIME_RST;
      cfg_q.turn_time     <= odc_pkg::TURN_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/odc_filter.sv =====
// ----------------------------------------------------------------------------
// odc_filter
// writes one sample into the four entry ring and takes the median of four
// ----------------------------------------------------------------------------
module odc_filter (
  input  odc_pkg::ring_t                   ring_i,
  input  logic [odc_pkg::PTR_W-1:0]        ptr_i,
  input  logic [odc_pkg::DIST_W-1:0]       raw_distance_i,
  input  logic [odc_pkg::STAT_W-1:0]       sensor_status_i,
  output odc_pkg::ring_t                   ring_o,
  output logic [odc_pkg::PTR_W-1:0]        ptr_o,
  output logic [odc_pkg::DIST_W-1:0]       distance_o
);

  logic [odc_pkg::DIST_W-1:0] sample;
  logic [odc_pkg::DIST_W-1:0] lo_a, hi_a, lo_b, hi_b, mid_lo, mid_hi;
  logic [odc_pkg::DIST_W:0]   mid_sum;

  always_comb begin
    sample = (sensor_status_i != '0) ? odc_pkg::INVALID_DISTANCE : raw_distance_i;
    ring_o = ring_i;
    ring_o[ptr_i] = sample;
    ptr_o = ptr_i + 1'b1;
  end

  // pairwise compare, then the inner two of the four are the middle pair
  always_comb begin
    lo_a = (ring_o[0] > ring_o[1]) ? ring_o[1] : ring_o[0];
    hi_a = (ring_o[0] > ring_o[1]) ? ring_o[0] : ring_o[1];
    lo_b = (ring_o[2] > ring_o[3]) ? ring_o[3] : ring_o[2];
    hi_b = (ring_o[2] > ring_o[3]) ? ring_o[2] : ring_o[3];
    mid_lo = (lo_a > lo_b) ? lo_a : lo_b;
    mid_hi = (hi_a > hi_b) ? hi_b : hi_a;
    mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
    distance_o = mid_sum[odc_pkg::DIST_W:1];
  end

endmodule

// ===== rtl/odc_mode_ctrl.sv =====
// ----------------------------------------------------------------------------
// odc_mode_ctrl
// drive mode rules: next state and result word for one item
// ----------------------------------------------------------------------------
module odc_mode_ctrl (
  input  odc_pkg::cfg_t                  cfg_i,
  input  odc_pkg::drive_state_t          state_i,
  input  odc_pkg::item_t                 item_i,
  input  odc_pkg::ring_t                 ring_i,
  input  logic [odc_pkg::PTR_W-1:0]      ptr_i,
  input  logic [odc_pkg::DIST_W-1:0]     distance_i,
  output odc_pkg::drive_state_t          state_o,
  output odc_pkg::result_t               result_o
);

  logic                         obstacle;
  logic                         too_close;
  logic                         wall_near;
  logic                         turn_done;
  logic                         backup_done;
  logic [odc_pkg::NOW_W-1:0]    now;

  always_comb begin
    now         = item_i.now_ms;
    too_close   = distance_i < {3'b000, cfg_i.too_close_thr};
    wall_near   = distance_i < {3'b000, cfg_i.wall_near_thr};
    turn_done   = now >= state_i.turn_deadline;
    backup_done = now >= state_i.backup_deadline;
    state_o     = state_i;

    if (item_i.command) begin
      state_o.mode = odc_pkg::MODE_CRUISE;
      obstacle     = state_i.held_distance < {3'b000, cfg_i.obstacle_thr};
    end else begin
      state_o.ring          = ring_i;
      state_o.ptr           = ptr_i;
      state_o.held_distance = distance_i;
      obstacle              = distance_i < {3'b000, cfg_i.obstacle_thr};

      unique case (state_i.mode)
        odc_pkg::MODE_CRUISE: begin
          if (obstacle) begin
            state_o.mode            = odc_pkg::MODE_AVOID;
            state_o.turn_right_last = ~distance_i[0];
          end else begin
            state_o.held_left  = odc_pkg::fwd(cfg_i.cruise_speed);
            state_o.held_right = odc_pkg::fwd(cfg_i.cruise_speed);
          end
        end
        odc_pkg::MODE_AVOID: begin
          if (too_close) begin
            state_o.mode            = odc_pkg::MODE_BACKUP;
            state_o.backup_deadline = now + {16'd0, cfg_i.backup_time};
          end else begin
            state_o.mode          = state_i.turn_right_last ? odc_pkg::MODE_RIGHT
                                                            : odc_pkg::MODE_LEFT;
            state_o.turn_deadline = now + {16'd0, cfg_i.turn_time};
          end
        end
        odc_pkg::MODE_LEFT: begin
          state_o.held_left  = odc_pkg::rev(cfg_i.turn_speed);
          state_o.held_right = odc_pkg::fwd(cfg_i.turn_speed);
          if (turn_done && !obstacle) begin
            state_o.mode            = odc_pkg::MODE_WALL;
            state_o.turn_right_last = 1'b0;
          end
        end
        odc_pkg::MODE_RIGHT: begin
          state_o.held_left  = odc_pkg::fwd(cfg_i.turn_speed);
          state_o.held_right = odc_pkg::rev(cfg_i.turn_speed);
          if (turn_done && !obstacle) begin
            state_o.mode            = odc_pkg::MODE_WALL;
            state_o.turn_right_last = 1'b1;
          end
        end
        odc_pkg::MODE_BACKUP: begin
          state_o.held_left  = odc_pkg::rev(cfg_i.slow_speed);
          state_o.held_right = odc_pkg::rev(cfg_i.slow_speed);
          if (backup_done) state_o.mode = odc_pkg::MODE_AVOID;
        end
        odc_pkg::MODE_WALL: begin
          if (obstacle) begin
            state_o.mode = odc_pkg::MODE_AVOID;
          end else if (wall_near) begin
            if (state_i.turn_right_last) begin
              state_o.held_left  = odc_pkg::fwd(cfg_i.cruise_speed);
              state_o.held_right = odc_pkg::fwd(cfg_i.slow_speed);
            end else begin
              state_o.held_left  = odc_pkg::fwd(cfg_i.slow_speed);
              state_o.held_right = odc_pkg::fwd(cfg_i.cruise_speed);
            end
          end else begin
            state_o.held_left  = odc_pkg::fwd(cfg_i.cruise_speed);
            state_o.held_right = odc_pkg::fwd(cfg_i.cruise_speed);
          end
        end
        // idle and the unused code stop the wheels
        default: begin
          state_o.held_left  = '0;
          state_o.held_right = '0;
        end
      endcase
    end

    result_o.left_speed        = state_o.held_left;
    result_o.right_speed       = state_o.held_right;
    result_o.obstacle_flag     = obstacle;
    result_o.filtered_distance = state_o.held_distance;
    result_o.mode              = state_o.mode;
  end

endmodule
